/* sv/csl_pkg.sv */
// shared constants for the cap set occupancy table
package csl_pkg;
   localparam int MaxDimsDefault     = 6;
   localparam int MaxSelectedDefault = 128;
   localparam int CountW             = 10;
   localparam logic [CountW-1:0] CountMax = 10'd1023;

   localparam logic [1:0] MODE_ADD  = 2'd0;
   localparam logic [1:0] MODE_UNDO = 2'd1;
   localparam logic [1:0] MODE_EVAL = 2'd2;

   localparam logic [0:0] CSR_DIMS   = 1'd0;
   localparam logic [0:0] CSR_TARGET = 1'd1;
endpackage

/* sv/csl_core.sv */
// sequencer, occupancy memory and summary walk
module csl_core
   import csl_pkg::*;
#(
   parameter int MAX_DIMS     = MaxDimsDefault,
   parameter int MAX_SELECTED = MaxSelectedDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            mode,
   input  logic [2*MAX_DIMS-1:0] point,
   input  logic [2:0]            dims,
   input  logic signed [9:0]     target,
   output logic                  busy,
   output logic                  done,
   output logic                  res_acc,
   output logic [7:0]            res_sel,
   output logic [8:0]            res_min,
   output logic [8:0]            res_max,
   output logic [18:0]           res_total,
   output logic [9:0]            res_dev,
   output logic [9:0]            res_free
);
   localparam int TabDepth = 3 ** MAX_DIMS;
   localparam int AW  = $clog2(TabDepth);
   localparam int NW  = AW + 1;
   localparam int SW  = $clog2(MAX_SELECTED);
   localparam int DW  = $clog2(MAX_SELECTED + 1);
   localparam int PW  = 2 * MAX_DIMS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLR    = 4'd1;
   localparam logic [3:0] S_CHK    = 4'd2;
   localparam logic [3:0] S_CHK2   = 4'd3;
   localparam logic [3:0] S_LREAD  = 4'd4;
   localparam logic [3:0] S_LADDR  = 4'd5;
   localparam logic [3:0] S_LWAIT  = 4'd6;
   localparam logic [3:0] S_LWR    = 4'd7;
   localparam logic [3:0] S_PASS1  = 4'd8;
   localparam logic [3:0] S_PASS2  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;
   localparam logic [3:0] S_UPOP   = 4'd11;
   localparam logic [3:0] S_UWAIT  = 4'd12;

   // table entry: selected mark above the count
   logic [CountW:0] tab_mem [TabDepth];
   logic [PW-1:0]   stk_mem [MAX_SELECTED];

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [DW-1:0]     k_ff, k_in;
   logic [PW-1:0]     p_ff, p_in;
   logic [1:0]        mode_ff, mode_in;
   logic              acc_ff, acc_in;
   logic              pass_ff, pass_in;
   logic [8:0]        min_ff, min_in;
   logic [8:0]        max_ff, max_in;
   logic [18:0]       tot_ff, tot_in;
   logic [9:0]        dev_ff, dev_in;
   logic [9:0]        free_ff, free_in;
   logic [NW-1:0]     walk_n;
   logic [AW:0]       w_ff, w_in;
   logic [2:0]        i_ff, i_in;
   logic [AW-1:0]     idx_ff, idx_in;

   logic [CountW:0]   rd_ff;
   logic [PW-1:0]     srd_ff;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [CountW:0]   wdata;
   logic              swe;
   logic [AW-1:0]     raddr;
   logic [SW-1:0]     saddr;

   logic [2:0]        deff;
   logic              pvalid;
   logic [AW-1:0]     third;
   logic [1:0]        ta, tb, tt;
   logic signed [10:0] ref_v;
   logic [CountW-1:0] cnt;

   always_comb begin
      deff = dims;
      if (dims == 3'd0) deff = 3'd1;
      else if (32'(dims) > MAX_DIMS) deff = 3'(MAX_DIMS);
   end

   // points covered by the summary walk, 3^d
   always_comb begin
      walk_n = NW'(1);
      for (int i = 0; i < MAX_DIMS; i++)
         if (i < 32'(deff)) walk_n = NW'(3 * 32'(walk_n));
   end

   always_comb begin
      pvalid = 1'b1;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (point[2*i +: 2] == 2'd3) pvalid = 1'b0;
         if (i >= 32'(deff) && point[2*i +: 2] != 2'd0) pvalid = 1'b0;
      end
   end

   // one trit per step for the table index of the third point
   always_comb begin
      ta = srd_ff[2*i_ff +: 2];
      tb = p_ff[2*i_ff +: 2];
      case (4'({ta, 2'b00}) + 4'(tb))
         4'd0, 4'd6, 4'd9:  tt = 2'd0;
         4'd2, 4'd5, 4'd8:  tt = 2'd1;
         default:           tt = 2'd2;
      endcase
      third = AW'(idx_ff + AW'(32'(tt) * 32'(w_ff)));
   end

   assign cnt   = rd_ff[CountW-1:0];
   assign ref_v = (target == -10'sd1) ? $signed({2'b00, min_ff}) : 11'(target);
   assign saddr = (state_ff == S_UPOP) ? SW'(depth_ff - DW'(1)) : SW'(k_ff);

   always_ff @(posedge clock) begin
      if (we) tab_mem[waddr] <= wdata;
      rd_ff <= tab_mem[raddr];
      if (swe) stk_mem[SW'(depth_ff)] <= p_ff;
      srd_ff <= stk_mem[saddr];
   end

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; depth_in = depth_ff; k_in = k_ff;
      p_in = p_ff; mode_in = mode_ff; acc_in = acc_ff; pass_in = pass_ff;
      min_in = min_ff; max_in = max_ff; tot_in = tot_ff; dev_in = dev_ff;
      free_in = free_ff; w_in = w_ff; i_in = i_ff; idx_in = idx_ff;
      we = 1'b0; waddr = addr_ff; wdata = '0; swe = 1'b0; raddr = addr_ff;
      done = 1'b0;
      case (state_ff)
         S_CLR: begin
            we = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (32'(addr_ff) == TabDepth - 1) begin
               addr_in = '0; state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in = mode; p_in = point; acc_in = 1'b0;
               i_in = '0;
               // table index of the point, built as base-3 sum
               idx_in = '0;
               for (int i = 0; i < MAX_DIMS; i++)
                  idx_in = AW'(32'(idx_in) + 32'(point[2*i +: 2]) * (3 ** i));
               addr_in = idx_in;
               if (mode == MODE_ADD) begin
                  if (pvalid && 32'(depth_ff) < MAX_SELECTED) state_in = S_CHK;
                  else state_in = S_PASS1;
               end else if (mode == MODE_UNDO) begin
                  if (depth_ff != '0) state_in = S_UPOP;
                  else state_in = S_PASS1;
               end else begin
                  acc_in = (mode == MODE_EVAL);
                  state_in = S_PASS1;
               end
               if (state_in == S_PASS1) begin
                  addr_in = '0; pass_in = 1'b0;
                  min_in = 9'd511; max_in = '0; tot_in = '0; free_in = '0;
                  dev_in = '0;
               end
            end
         end
         S_CHK: state_in = S_CHK2;  // read of the point entry
         S_CHK2: begin
            if (rd_ff == '0) begin
               acc_in = 1'b1;
               we = 1'b1; wdata = {1'b1, {CountW{1'b0}}};
               swe = 1'b1; depth_in = depth_ff + DW'(1);
               k_in = '0; state_in = S_LREAD;
            end else begin
               // occupied point: straight to the summary walk
               state_in = S_PASS1; addr_in = '0; pass_in = 1'b0;
               min_in = 9'd511; max_in = '0; tot_in = '0; free_in = '0;
               dev_in = '0;
            end
         end
         S_UPOP: state_in = S_UWAIT;
         S_UWAIT: begin
            p_in = srd_ff; depth_in = depth_ff - DW'(1);
            idx_in = '0;
            for (int i = 0; i < MAX_DIMS; i++)
               idx_in = AW'(32'(idx_in) + 32'(srd_ff[2*i +: 2]) * (3 ** i));
            we = 1'b1; waddr = idx_in; wdata = '0;
            acc_in = 1'b1; k_in = '0; state_in = S_LREAD;
         end
         S_LREAD: begin
            // loop over earlier points (in add mode depth already counts the new one)
            if ((mode_ff == MODE_ADD && k_ff == depth_ff - DW'(1)) ||
                (mode_ff == MODE_UNDO && k_ff == depth_ff)) begin
               state_in = S_PASS1; addr_in = '0; pass_in = 1'b0;
               min_in = 9'd511; max_in = '0; tot_in = '0; free_in = '0;
               dev_in = '0;
            end else begin
               state_in = S_LADDR; i_in = '0; idx_in = '0;
               w_in = '0; w_in[0] = 1'b1;
            end
         end
         S_LADDR: begin
            // srd_ff holds stack entry k; one trit a cycle
            idx_in = third;
            w_in = AW'(3) * w_ff;
            i_in = i_ff + 3'd1;
            if (32'(i_ff) == MAX_DIMS - 1) begin
               addr_in = third; state_in = S_LWAIT;
            end
         end
         S_LWAIT: state_in = S_LWR;
         S_LWR: begin
            we = 1'b1; wdata = rd_ff;
            if (!rd_ff[CountW]) begin
               if (mode_ff == MODE_ADD && cnt < CountMax) wdata = rd_ff + 1'b1;
               if (mode_ff == MODE_UNDO && cnt != '0) wdata = rd_ff - 1'b1;
            end
            k_in = k_ff + DW'(1); state_in = S_LREAD;
         end
         S_PASS1, S_PASS2: begin
            // data for addr_ff arrives in the cycle after the address
            raddr = addr_ff;
            if (state_ff == S_PASS1) begin
               state_in = S_PASS2;
            end else begin
               if (!rd_ff[CountW]) begin
                  if (!pass_ff) begin
                     if (9'(cnt) < min_ff && cnt < 10'd512) min_in = 9'(cnt);
                     if (cnt > 10'(max_ff)) max_in = 9'(cnt);
                     tot_in = tot_ff + 19'(cnt);
                     if (cnt == '0) free_in = free_ff + 10'd1;
                  end else if (cnt != '0 && $signed({1'b0, cnt}) != ref_v) begin
                     dev_in = dev_ff + 10'd1;
                  end
               end
               state_in = S_PASS1;
               if (32'(addr_ff) + 1 >= 32'(walk_n)) begin
                  addr_in = '0;
                  if (pass_ff) state_in = S_DONE;
                  else pass_in = 1'b1;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         S_DONE: begin
            done = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; addr_ff <= '0; depth_ff <= '0;
      end else begin
         state_ff <= state_in; addr_ff <= addr_in; depth_ff <= depth_in;
      end
      k_ff <= k_in; p_ff <= p_in; mode_ff <= mode_in; acc_ff <= acc_in;
      pass_ff <= pass_in; min_ff <= min_in; max_ff <= max_in; tot_ff <= tot_in;
      dev_ff <= dev_in; free_ff <= free_in; w_ff <= w_in;
      i_ff <= i_in; idx_ff <= idx_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign res_acc   = acc_ff;
   assign res_sel   = 8'(depth_ff);
   assign res_min   = min_ff;
   assign res_max   = max_ff;
   assign res_total = tot_ff;
   assign res_dev   = dev_ff;
   assign res_free  = free_ff;
endmodule

/* sv/cap_set_line_occupancy_table.sv */
// top level: stream ports, configuration registers and result register
// add or undo first updates the line counts against each earlier point in the set,
//   then runs a two-pass summary walk over the 3^d points; evaluate only the walk
// one transaction at a time: a new request waits until the core is idle and the
//   result register is empty
// reset: synchronous; a clearing pass over all 3^MAX_DIMS entries (729) zeroes the
//   table before the first request is taken
module cap_set_line_occupancy_table
   import csl_pkg::*;
#(
   parameter int MAX_DIMS     = MaxDimsDefault,
   parameter int MAX_SELECTED = MaxSelectedDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], point[13:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // accepted, selected_count, min_lines, max_lines,
                                    // total_lines, deviant_count, free_count
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   logic [2:0]        dims_ff;
   logic signed [9:0] target_ff;
   logic              busy, done, start;
   logic              acc;
   logic [7:0]        sel;
   logic [8:0]        mn, mx;
   logic [18:0]       tot;
   logic [9:0]        dev, fr;
   logic              vld_ff;
   logic [65:0]       out_ff;

   // one transaction in flight; result register holds until taken
   assign req_tready = !busy && !vld_ff;
   assign start      = req_tvalid && req_tready;

   csl_core #(.MAX_DIMS(MAX_DIMS), .MAX_SELECTED(MAX_SELECTED)) u_core (
      .clock(clock), .reset(reset), .start(start),
      .mode(req_tdata[1:0]), .point(req_tdata[2 +: 2*MAX_DIMS]),
      .dims(dims_ff), .target(target_ff), .busy(busy), .done(done),
      .res_acc(acc), .res_sel(sel), .res_min(mn), .res_max(mx),
      .res_total(tot), .res_dev(dev), .res_free(fr));

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 3'd6; target_ff <= -10'sd1; vld_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_DIMS) dims_ff <= csr_wdata[2:0];
         if (csr_we && csr_index == CSR_TARGET) target_ff <= csr_wdata;
         if (done) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
      if (done) out_ff <= {fr, dev, tot, mx, mn, sel, acc};
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {6'd0, out_ff};
endmodule

/* tb/cap_set_line_occupancy_table_tb.sv */
// testbench for the cap set line occupancy table
module cap_set_line_occupancy_table_tb;
   import csl_pkg::*;

   localparam int TableSize = 729;
   localparam int StackSize = 128;
   localparam int CycleLimit = 20_000_000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // packed from the highest field down, so mode lands in the low bits
   typedef struct packed {
      logic [11:0] point;
      logic [1:0]  mode;
   } request_type;

   // packed from the highest field down, so accepted lands in bit 0
   typedef struct packed {
      logic [9:0]  free_count;
      logic [9:0]  deviant_count;
      logic [18:0] total_lines;
      logic [8:0]  max_lines;
      logic [8:0]  min_lines;
      logic [7:0]  selected_count;
      logic        accepted;
   } summary_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // mode[1:0], point[13:2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // accepted, selected_count, min_lines, max_lines,
                                  // total_lines, deviant_count, free_count
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_DIMS;
   logic [9:0]  csr_wdata = '0;

   cap_set_line_occupancy_table DUT (.*);

   always #2 clock = ~clock;

   // predictor state: per-point line counts, selection marks and the point stack
   int unsigned line_count [TableSize];
   bit          is_selected [TableSize];
   logic [11:0] point_stack [StackSize];
   int          stack_level = 0;
   int          dims_setting = 6;
   int          target_setting = -1;

   request_type pending_requests[$];
   summary_type expected_summaries[$];
   int       errors = 0;
   bit       idling_on = 1'b1;
   bit       long_hold_req = 1'b0;
   int unsigned cycle_count = 0;

   function automatic int effective_dims();
      if (dims_setting == 0) return 1;
      if (dims_setting > 6) return 6;
      return dims_setting;
   endfunction

   function automatic int point_slot(logic [11:0] p);
      int idx;
      int w;
      idx = 0;
      w = 1;
      for (int i = 0; i < 6; i++) begin
         idx += int'(p[2*i +: 2]) * w;
         w *= 3;
      end
      return idx;
   endfunction

   // third point on the line through a and b, computed over all six trits
   function automatic int line_third_slot(logic [11:0] a, logic [11:0] b);
      int idx;
      int w;
      idx = 0;
      w = 1;
      for (int i = 0; i < 6; i++) begin
         idx += ((6 - int'(a[2*i +: 2]) - int'(b[2*i +: 2])) % 3) * w;
         w *= 3;
      end
      return idx;
   endfunction

   function automatic bit try_add(logic [11:0] p);
      int d;
      int s;
      int t;
      d = effective_dims();
      for (int i = 0; i < 6; i++) begin
         if (p[2*i +: 2] == 2'd3) return 1'b0;
         if (i >= d && p[2*i +: 2] != 2'd0) return 1'b0;
      end
      if (stack_level >= StackSize) return 1'b0;
      s = point_slot(p);
      if (is_selected[s] || line_count[s] != 0) return 1'b0;
      is_selected[s] = 1'b1;
      for (int k = 0; k < stack_level; k++) begin
         t = line_third_slot(point_stack[k], p);
         if (!is_selected[t] && line_count[t] < 1023) line_count[t]++;
      end
      point_stack[stack_level] = p;
      stack_level++;
      return 1'b1;
   endfunction

   function automatic bit try_undo();
      logic [11:0] last;
      int s;
      int t;
      if (stack_level == 0) return 1'b0;
      stack_level--;
      last = point_stack[stack_level];
      s = point_slot(last);
      is_selected[s] = 1'b0;
      line_count[s] = 0;
      for (int k = 0; k < stack_level; k++) begin
         t = line_third_slot(point_stack[k], last);
         if (!is_selected[t] && line_count[t] > 0) line_count[t]--;
      end
      return 1'b1;
   endfunction

   function automatic summary_type apply_request(request_type r);
      summary_type sm;
      int n;
      int unsigned mn;
      int unsigned mx;
      int unsigned tot;
      int unsigned dev;
      int unsigned fr;
      int refc;
      case (r.mode)
         MODE_ADD:  sm.accepted = try_add(r.point);
         MODE_UNDO: sm.accepted = try_undo();
         MODE_EVAL: sm.accepted = 1'b1;
         default:   sm.accepted = 1'b0;
      endcase
      n = 1;
      for (int i = 0; i < effective_dims(); i++) n *= 3;
      mn = 511; mx = 0; tot = 0; dev = 0; fr = 0;
      for (int i = 0; i < n; i++) begin
         if (!is_selected[i]) begin
            if (line_count[i] < mn) mn = line_count[i];
            if (line_count[i] > mx) mx = line_count[i];
            tot += line_count[i];
            if (line_count[i] == 0) fr++;
         end
      end
      refc = (target_setting == -1) ? int'(mn) : target_setting;
      for (int i = 0; i < n; i++)
         if (!is_selected[i] && line_count[i] != 0 && int'(line_count[i]) != refc) dev++;
      sm.selected_count = stack_level[7:0];
      sm.min_lines = mn[8:0];
      sm.max_lines = mx[8:0];
      sm.total_lines = tot[18:0];
      sm.deviant_count = dev[9:0];
      sm.free_count = fr[9:0];
      return sm;
   endfunction

   // driver: predicts each accepted transaction, then offers the next one
   int src_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_summaries.push_back(apply_request(request_type'(req_tdata[13:0])));
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
               src_gap <= $urandom_range(1, 18) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_tdata <= {2'b00, pending_requests.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction, paces rsp_tready
   int sink_stall = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   always @(posedge clock) begin
      summary_type got;
      summary_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("cap_set_line_occupancy_table regression: fail");
         $finish;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = summary_type'(rsp_tdata[65:0]);
            if (expected_summaries.size() == 0) begin
               $error("result transaction with no request pending");
               errors++;
            end else begin
               want = expected_summaries.pop_front();
               if (got.accepted !== want.accepted) begin
                  $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
                  errors++;
               end
               if (got.selected_count !== want.selected_count) begin
                  $error("selected_count: expected %0d actual %0d",
                         want.selected_count, got.selected_count);
                  errors++;
               end
               if (got.min_lines !== want.min_lines) begin
                  $error("min_lines: expected %0d actual %0d", want.min_lines, got.min_lines);
                  errors++;
               end
               if (got.max_lines !== want.max_lines) begin
                  $error("max_lines: expected %0d actual %0d", want.max_lines, got.max_lines);
                  errors++;
               end
               if (got.total_lines !== want.total_lines) begin
                  $error("total_lines: expected %0d actual %0d",
                         want.total_lines, got.total_lines);
                  errors++;
               end
               if (got.deviant_count !== want.deviant_count) begin
                  $error("deviant_count: expected %0d actual %0d",
                         want.deviant_count, got.deviant_count);
                  errors++;
               end
               if (got.free_count !== want.free_count) begin
                  $error("free_count: expected %0d actual %0d",
                         want.free_count, got.free_count);
                  errors++;
               end
            end
         end
         // one long hold-off so results back up and the input stalls
         if (long_hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 6000;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [11:0] random_point(int d);
      logic [11:0] p;
      p = '0;
      for (int i = 0; i < d; i++) p[2*i +: 2] = 2'($urandom_range(0, 2));
      return p;
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_tvalid || expected_summaries.size() != 0)
         @(posedge clock);
      // margin after the last result before the next register write
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [9:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DIMS) dims_setting = int'(value[2:0]);
      else target_setting = value[9] ? int'(value) - 1024 : int'(value);
   endtask

   task automatic push(logic [1:0] m, logic [11:0] p);
      request_type r;
      r.mode = m;
      r.point = p;
      pending_requests.push_back(r);
   endtask

   // mostly adds of in-range points mixed with short undo runs, evaluations and noise
   task automatic random_phase(int count);
      int d;
      int sel;
      d = effective_dims();
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) push(MODE_ADD, random_point(d));
         else if (sel < 65) push(MODE_ADD, 12'($urandom()));
         else if (sel < 80) begin
            repeat ($urandom_range(1, 4)) push(MODE_UNDO, 12'($urandom()));
         end else if (sel < 95) push(MODE_EVAL, 12'($urandom()));
         else push(MODE_UNUSED, 12'($urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < TableSize; i++) begin
         line_count[i] = 0;
         is_selected[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, empty undo, extreme points, occupied and invalid points
      push(MODE_EVAL, 12'h000);
      push(MODE_UNDO, 12'h000);
      push(MODE_ADD, 12'h000);
      push(MODE_ADD, 12'hAAA);
      push(MODE_ADD, 12'hAAA);        // already selected
      push(MODE_ADD, 12'h555);        // third point of the line, count nonzero
      push(MODE_ADD, 12'hFFF);        // trit code 3
      push(MODE_ADD, 12'h003);
      push(MODE_ADD, 12'h001);
      push(MODE_UNUSED, 12'h001);
      push(MODE_EVAL, 12'hFFF);
      push(MODE_UNDO, 12'h000);
      push(MODE_EVAL, 12'h000);
      wait_idle();

      write_reg(CSR_DIMS, 10'd1);
      write_reg(CSR_TARGET, 10'd0);
      push(MODE_ADD, 12'h004);        // nonzero trit above the dimension
      push(MODE_ADD, 12'h002);
      random_phase(30);
      wait_idle();

      // the sender waits here until every result is back
      write_reg(CSR_DIMS, 10'd0);
      write_reg(CSR_TARGET, 10'h3FF);
      random_phase(30);
      wait_idle();

      write_reg(CSR_DIMS, 10'd2);
      random_phase(70);
      wait_idle();

      write_reg(CSR_DIMS, 10'd3);
      write_reg(CSR_TARGET, 10'd1);
      random_phase(90);
      // stall the result side while requests keep coming
      long_hold_req <= 1'b1;
      random_phase(20);
      wait_idle();

      write_reg(CSR_DIMS, 10'd4);
      write_reg(CSR_TARGET, 10'h3FF);
      random_phase(110);
      wait_idle();

      write_reg(CSR_DIMS, 10'd5);
      write_reg(CSR_TARGET, 10'd364);
      random_phase(60);
      wait_idle();

      write_reg(CSR_DIMS, 10'd3);
      write_reg(CSR_TARGET, 10'h3FB);  // negative reference
      random_phase(60);
      wait_idle();

      write_reg(CSR_TARGET, 10'h200);  // most negative reference
      write_reg(CSR_DIMS, 10'd7);      // above range, acts as six
      random_phase(60);
      wait_idle();

      write_reg(CSR_DIMS, 10'd6);
      write_reg(CSR_TARGET, 10'd2);
      random_phase(40);
      wait_idle();

      // closing stretch without idling on either side
      idling_on = 1'b0;
      write_reg(CSR_DIMS, 10'd2);
      write_reg(CSR_TARGET, 10'h3FF);
      random_phase(80);
      wait_idle();

      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("cap_set_line_occupancy_table regression: pass");
      else
         $display("cap_set_line_occupancy_table regression: fail");
      $finish;
   end
endmodule
